// ----- src/ipatv_pkg.sv -----
// Shared types and constants for the IP address text validator.
// Used by the front end, the character queue and the back end; no dependencies.
`default_nettype none

package ipatv_pkg;

    // Character classes produced by the front end
    typedef enum logic [2:0] {
        CH_OTHER,
        CH_DOT,
        CH_COLON,
        CH_DEC,
        CH_HEX
    } char_class_t;

    typedef enum logic [1:0] {
        KIND_UNKNOWN,
        KIND_V4,
        KIND_V6
    } addr_kind_t;

    typedef enum logic [1:0] {
        CLASS_NONE,
        CLASS_V4,
        CLASS_V6
    } addr_class_t;

    // One classified character as it travels through the queue
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        is_final;
    } char_item_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [9:0] V4_MAX_VALUE  = 10'd255;
    localparam logic [9:0] VALUE_SAT     = 10'd1023;
    localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
    localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
    localparam logic [3:0] MAX_GROUPS    = 4'd8;
    localparam logic [3:0] V4_LAST_GROUP = 4'd3;
    localparam logic [3:0] V6_MAX_COMPR  = 4'd7;

endpackage

`default_nettype wire

// ----- src/ipatv_front.sv -----
// Front end: takes character requests, folds case and classifies each character.
// Depends on ipatv_pkg; feeds ipatv_queue.
`default_nettype none

module ipatv_front (
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            text_char,
    input  wire logic                  is_final_char,
    input  wire logic                  queue_full,
    output logic                       push,
    output ipatv_pkg::char_item_t      item
);

    logic [7:0] lc;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        lc = text_char;
        if (text_char >= 8'h41 && text_char <= 8'h5A)
        begin
            lc = text_char + 8'h20;
        end
        item.digit    = lc[3:0];
        item.is_final = is_final_char;
        if (lc == 8'h2E)
        begin
            item.cls = ipatv_pkg::CH_DOT;
        end
        else if (lc == 8'h3A)
        begin
            item.cls = ipatv_pkg::CH_COLON;
        end
        else if (lc >= 8'h30 && lc <= 8'h39)
        begin
            item.cls = ipatv_pkg::CH_DEC;
        end
        else if (lc >= 8'h61 && lc <= 8'h66)
        begin
            item.cls = ipatv_pkg::CH_HEX;
        end
        else
        begin
            item.cls = ipatv_pkg::CH_OTHER;
        end
    end

endmodule

`default_nettype wire

// ----- src/ipatv_queue.sv -----
// Short FIFO of classified characters between front end and back end.
// Depends on ipatv_pkg.
`default_nettype none

module ipatv_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire ipatv_pkg::char_item_t push_item,
    input  wire logic                  pop,
    output ipatv_pkg::char_item_t      head,
    output logic                       head_valid,
    output logic                       full
);

    ipatv_pkg::char_item_t entry_reg [ipatv_pkg::QUEUE_DEPTH];

    logic [ipatv_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ipatv_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ipatv_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == ipatv_pkg::QUEUE_CNT_W'(ipatv_pkg::QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ipatv_pkg::QUEUE_PTR_W'(ipatv_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ipatv_pkg::QUEUE_PTR_W'(ipatv_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/ipatv_back.sv -----
// Back end: per-string parse state, the compression setting and the result register.
// Depends on ipatv_pkg; consumes items from ipatv_queue.
`default_nettype none

module ipatv_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_data,
    input  wire ipatv_pkg::char_item_t head,
    input  wire logic                  head_valid,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 address_class
);

    logic                  allow_reg;
    ipatv_pkg::addr_kind_t kind_reg, kind_next, kind_upd;
    logic [3:0]            gc_reg, gc_next, gc_upd;
    logic [2:0]            dc_reg, dc_next, dc_upd;
    logic [9:0]            gv_reg, gv_next, gv_upd;
    logic                  fdz_reg, fdz_next, fdz_upd;
    logic                  cs_reg, cs_next, cs_upd;
    logic                  pwc_reg, pwc_next, pwc_upd;
    logic                  inv_reg, inv_next, inv_upd;
    logic                  out_valid_reg, out_valid_next;
    ipatv_pkg::addr_class_t class_reg, class_next, class_fin;

    logic [13:0] gv_x10;
    logic        v4_ok;
    logic        v4_ok_fin;
    logic        lone_colon;
    logic [3:0]  gc_fin;
    logic        inv_fin;
    logic        out_free;

    assign out_free      = !out_valid_reg || !out_stall;
    // Hold a final character until the result register can take its result
    assign pop           = head_valid && (!head.is_final || out_free);
    assign out_valid     = out_valid_reg;
    assign address_class = class_reg;

    assign gv_x10 = {1'b0, gv_reg, 3'b000} + {3'b000, gv_reg, 1'b0} + {10'd0, head.digit};
    assign v4_ok  = (dc_reg != 3'd0) && (dc_reg <= ipatv_pkg::V4_MAX_DIGITS)
                    && (gv_reg <= ipatv_pkg::V4_MAX_VALUE) && !(fdz_reg && dc_reg > 3'd1);

    // One character of the parse
    always_comb
    begin
        kind_upd = kind_reg;
        gc_upd   = gc_reg;
        dc_upd   = dc_reg;
        gv_upd   = gv_reg;
        fdz_upd  = fdz_reg;
        cs_upd   = cs_reg;
        pwc_upd  = 1'b0;
        inv_upd  = inv_reg;
        case (head.cls)
            ipatv_pkg::CH_DOT:
            begin
                if (kind_reg == ipatv_pkg::KIND_V6 || !v4_ok)
                begin
                    inv_upd = 1'b1;
                end
                kind_upd = ipatv_pkg::KIND_V4;
                if (gc_reg >= ipatv_pkg::MAX_GROUPS)
                begin
                    inv_upd = 1'b1;
                end
                else
                begin
                    gc_upd = gc_reg + 4'd1;
                end
                dc_upd  = 3'd0;
                gv_upd  = 10'd0;
                fdz_upd = 1'b0;
            end
            ipatv_pkg::CH_COLON:
            begin
                if (kind_reg == ipatv_pkg::KIND_V4)
                begin
                    inv_upd = 1'b1;
                end
                kind_upd = ipatv_pkg::KIND_V6;
                if (pwc_reg)
                begin
                    if (cs_reg || !allow_reg)
                    begin
                        inv_upd = 1'b1;
                    end
                    cs_upd = 1'b1;
                end
                else if (dc_reg != 3'd0)
                begin
                    if (gc_reg >= ipatv_pkg::MAX_GROUPS)
                    begin
                        inv_upd = 1'b1;
                    end
                    else
                    begin
                        gc_upd = gc_reg + 4'd1;
                    end
                end
                else if (gc_reg != 4'd0 || cs_reg)
                begin
                    inv_upd = 1'b1;
                end
                dc_upd  = 3'd0;
                gv_upd  = 10'd0;
                fdz_upd = 1'b0;
                pwc_upd = 1'b1;
            end
            ipatv_pkg::CH_DEC, ipatv_pkg::CH_HEX:
            begin
                // Digit right after a single leading colon
                if (pwc_reg && !cs_reg && gc_reg == 4'd0)
                begin
                    inv_upd = 1'b1;
                end
                if (dc_reg >= ipatv_pkg::V6_MAX_DIGITS)
                begin
                    inv_upd = 1'b1;
                end
                else
                begin
                    if (dc_reg == 3'd0)
                    begin
                        fdz_upd = (head.cls == ipatv_pkg::CH_DEC) && (head.digit == 4'd0);
                    end
                    dc_upd = dc_reg + 3'd1;
                    if (head.cls == ipatv_pkg::CH_HEX || gv_x10 > {4'd0, ipatv_pkg::VALUE_SAT})
                    begin
                        gv_upd = ipatv_pkg::VALUE_SAT;
                    end
                    else
                    begin
                        gv_upd = gv_x10[9:0];
                    end
                end
            end
            default:
            begin
                inv_upd = 1'b1;
            end
        endcase
    end

    // Verdict on the string once its last character is applied
    always_comb
    begin
        lone_colon = (head.cls == ipatv_pkg::CH_COLON) && !pwc_reg;
        v4_ok_fin  = (dc_upd != 3'd0) && (dc_upd <= ipatv_pkg::V4_MAX_DIGITS)
                     && (gv_upd <= ipatv_pkg::V4_MAX_VALUE) && !(fdz_upd && dc_upd > 3'd1);
        gc_fin     = gc_upd;
        inv_fin    = 1'b0;
        if (dc_upd != 3'd0)
        begin
            if (gc_upd >= ipatv_pkg::MAX_GROUPS)
            begin
                inv_fin = 1'b1;
            end
            else
            begin
                gc_fin = gc_upd + 4'd1;
            end
        end
        class_fin = ipatv_pkg::CLASS_NONE;
        if (!inv_upd)
        begin
            case (kind_upd)
                ipatv_pkg::KIND_V4:
                begin
                    if (v4_ok_fin && gc_upd == ipatv_pkg::V4_LAST_GROUP)
                    begin
                        class_fin = ipatv_pkg::CLASS_V4;
                    end
                end
                ipatv_pkg::KIND_V6:
                begin
                    if (!lone_colon && !inv_fin)
                    begin
                        if (cs_upd ? (gc_fin <= ipatv_pkg::V6_MAX_COMPR)
                                   : (gc_fin == ipatv_pkg::MAX_GROUPS))
                        begin
                            class_fin = ipatv_pkg::CLASS_V6;
                        end
                    end
                end
                default:
                begin
                    class_fin = ipatv_pkg::CLASS_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        kind_next      = kind_reg;
        gc_next        = gc_reg;
        dc_next        = dc_reg;
        gv_next        = gv_reg;
        fdz_next       = fdz_reg;
        cs_next        = cs_reg;
        pwc_next       = pwc_reg;
        inv_next       = inv_reg;
        class_next     = class_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (pop)
        begin
            if (head.is_final)
            begin
                // Drop the string state and load the result
                kind_next      = ipatv_pkg::KIND_UNKNOWN;
                gc_next        = 4'd0;
                dc_next        = 3'd0;
                gv_next        = 10'd0;
                fdz_next       = 1'b0;
                cs_next        = 1'b0;
                pwc_next       = 1'b0;
                inv_next       = 1'b0;
                class_next     = class_fin;
                out_valid_next = 1'b1;
            end
            else
            begin
                kind_next = kind_upd;
                gc_next   = gc_upd;
                dc_next   = dc_upd;
                gv_next   = gv_upd;
                fdz_next  = fdz_upd;
                cs_next   = cs_upd;
                pwc_next  = pwc_upd;
                inv_next  = inv_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_reg     <= 1'b1;
            kind_reg      <= ipatv_pkg::KIND_UNKNOWN;
            gc_reg        <= 4'd0;
            dc_reg        <= 3'd0;
            gv_reg        <= 10'd0;
            fdz_reg       <= 1'b0;
            cs_reg        <= 1'b0;
            pwc_reg       <= 1'b0;
            inv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                allow_reg <= cfg_data;
            end
            kind_reg      <= kind_next;
            gc_reg        <= gc_next;
            dc_reg        <= dc_next;
            gv_reg        <= gv_next;
            fdz_reg       <= fdz_next;
            cs_reg        <= cs_next;
            pwc_reg       <= pwc_next;
            inv_reg       <= inv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
    end

endmodule

`default_nettype wire

// ----- src/ip_address_text_validator.sv -----
// IP address text validator, top level. out_valid rises once the request carrying the last
// character has been written into the queue and its parse step has loaded the result register.
// Throughput: one character per cycle while neither side stalls, set by the parse step in the back
// end; a four-entry queue absorbs output stalls before the input stalls.
// Reset: asynchronous, active low; clears the queue, the parse state and the result
// valid, and sets IPv6 compression to allowed.
`default_nettype none

module ip_address_text_validator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] text_char,
    input  wire logic       is_final_char,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      address_class
);

    ipatv_pkg::char_item_t front_item;
    ipatv_pkg::char_item_t head;
    logic                  push;
    logic                  pop;
    logic                  head_valid;
    logic                  queue_full;

    assign cfg_ready = 1'b1;

    ipatv_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_char     (text_char),
        .is_final_char (is_final_char),
        .queue_full    (queue_full),
        .push          (push),
        .item          (front_item)
    );

    ipatv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    ipatv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .address_class (address_class)
    );

    // Never write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !queue_full)
        else $error("push into full queue");

    // A final character leaves the queue only when the result register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.is_final) |-> (!out_valid || !out_stall))
        else $error("result overwritten while stalled");

    // A consumed final character yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.is_final) |=> out_valid)
        else $error("result missing after final character");

    // Pop only what the queue holds
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- test/ip_address_text_validator_tb.sv -----
// Testbench for ip_address_text_validator: sends address strings one character per request
// and checks each classification against a scoreboard with its own parser model.
// Depends on ipatv_pkg for the result and address kind enums and the group limits.
`timescale 1ns / 100ps

localparam logic [7:0] ASCII_DOT     = 8'h2e;
localparam logic [7:0] ASCII_COLON   = 8'h3a;
localparam logic [7:0] ASCII_ZERO    = 8'h30;
localparam logic [7:0] ASCII_NINE    = 8'h39;
localparam logic [7:0] ASCII_LOWER_A = 8'h61;
localparam logic [7:0] ASCII_LOWER_F = 8'h66;
localparam logic [7:0] ASCII_UPPER_A = 8'h41;
localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
localparam logic [7:0] CASE_OFFSET   = 8'h20;

class address_scoreboard;
    logic                   compression_on;
    ipatv_pkg::addr_kind_t  kind;
    logic [3:0]             groups;
    logic [2:0]             digits;
    logic [9:0]             value;
    logic                   lead_zero;
    logic                   double_colon;
    logic                   after_colon;
    logic                   broken;
    ipatv_pkg::addr_class_t expected_q[$];
    int unsigned            chars_noted;
    int unsigned            strings_noted;
    int unsigned            results_checked;
    int unsigned            mismatches;

    function new();
        compression_on  = 1'b1;
        chars_noted     = 0;
        strings_noted   = 0;
        results_checked = 0;
        mismatches      = 0;
        clear_text();
    endfunction

    function void clear_text();
        kind         = ipatv_pkg::KIND_UNKNOWN;
        groups       = '0;
        digits       = '0;
        value        = '0;
        lead_zero    = 1'b0;
        double_colon = 1'b0;
        after_colon  = 1'b0;
        broken       = 1'b0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function bit v4_group_fits();
        if (digits == 0 || digits > ipatv_pkg::V4_MAX_DIGITS) return 1'b0;
        if (value > ipatv_pkg::V4_MAX_VALUE) return 1'b0;
        if (lead_zero && digits > 1) return 1'b0;
        return 1'b1;
    endfunction

    function void close_group();
        if (groups >= ipatv_pkg::MAX_GROUPS) broken = 1'b1;
        else groups = groups + 4'd1;
    endfunction

    function void open_group();
        digits    = '0;
        value     = '0;
        lead_zero = 1'b0;
    endfunction

    function void parse_char(logic [7:0] c);
        logic [7:0]  ch;
        logic        is_dec;
        logic        is_hex;
        int unsigned next_val;
        ch = c;
        if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) ch = ch + CASE_OFFSET;
        if (ch == ASCII_DOT) begin
            if (kind == ipatv_pkg::KIND_V6) broken = 1'b1;
            kind = ipatv_pkg::KIND_V4;
            if (!v4_group_fits()) broken = 1'b1;
            close_group();
            open_group();
            after_colon = 1'b0;
        end else if (ch == ASCII_COLON) begin
            if (kind == ipatv_pkg::KIND_V4) broken = 1'b1;
            kind = ipatv_pkg::KIND_V6;
            if (after_colon) begin
                if (double_colon || !compression_on) broken = 1'b1;
                double_colon = 1'b1;
            end else if (digits != 0) begin
                close_group();
            end else if (groups != 0 || double_colon) begin
                broken = 1'b1;
            end
            open_group();
            after_colon = 1'b1;
        end else begin
            is_dec = (ch >= ASCII_ZERO && ch <= ASCII_NINE);
            is_hex = (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_F);
            if (!is_dec && !is_hex) begin
                broken = 1'b1;
            end else begin
                // a single colon cannot open the string
                if (after_colon && !double_colon && groups == 0) broken = 1'b1;
                if (digits >= ipatv_pkg::V6_MAX_DIGITS) begin
                    broken = 1'b1;
                end else begin
                    if (digits == 0) lead_zero = (ch == ASCII_ZERO);
                    digits = digits + 3'd1;
                    if (is_hex) begin
                        value = ipatv_pkg::VALUE_SAT;
                    end else begin
                        next_val = int'(value) * 10 + int'(ch - ASCII_ZERO);
                        value = (next_val > int'(ipatv_pkg::VALUE_SAT))
                                ? ipatv_pkg::VALUE_SAT : next_val[9:0];
                    end
                end
            end
            after_colon = 1'b0;
        end
    endfunction

    function ipatv_pkg::addr_class_t end_class(logic lone_colon_end);
        if (broken) return ipatv_pkg::CLASS_NONE;
        if (kind == ipatv_pkg::KIND_V4) begin
            if (!v4_group_fits()) return ipatv_pkg::CLASS_NONE;
            close_group();
            if (broken || groups != 4'd4) return ipatv_pkg::CLASS_NONE;
            return ipatv_pkg::CLASS_V4;
        end
        if (kind == ipatv_pkg::KIND_V6) begin
            if (lone_colon_end) return ipatv_pkg::CLASS_NONE;
            if (digits != 0) close_group();
            if (broken) return ipatv_pkg::CLASS_NONE;
            if (double_colon)
                return (groups <= ipatv_pkg::V6_MAX_COMPR)
                       ? ipatv_pkg::CLASS_V6 : ipatv_pkg::CLASS_NONE;
            return (groups == ipatv_pkg::MAX_GROUPS)
                   ? ipatv_pkg::CLASS_V6 : ipatv_pkg::CLASS_NONE;
        end
        return ipatv_pkg::CLASS_NONE;
    endfunction

    function void note_request(logic [7:0] c, logic fin);
        logic                   was_colon;
        ipatv_pkg::addr_class_t cls;
        was_colon = after_colon;
        chars_noted++;
        parse_char(c);
        if (fin) begin
            cls = end_class(c == ASCII_COLON && !was_colon);
            expected_q = {expected_q, cls};
            strings_noted++;
            clear_text();
        end
    endfunction

    function void check_result(ipatv_pkg::addr_class_t got);
        ipatv_pkg::addr_class_t want;
        if (expected_q.size() == 0) begin
            $error("address_class: got %0d with no string pending", got);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        if (want != got) begin
            $error("address_class: expected %0d, actual %0d", want, got);
            mismatches++;
        end
    endfunction
endclass

module ip_address_text_validator_tb;

    localparam int RANDOM_ITEMS = 900;
    localparam int RANDOM_PHASES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD = 60;
    localparam int HOLD_AFTER_CHARS = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] text_char;
    logic       is_final_char;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] address_class;

    address_scoreboard sb = new();
    bit          idle_on;
    int unsigned cycle_count = 0;
    int unsigned settings_used;

    string directed_compressed[] = '{
        "0.0.0.0", "255.255.255.255", "256.1.1.1", "01.1.1.1", "1.2.3", "1.2.3.4.5",
        "1..2.3", "1.2:3.4", "2001:DB8:0:0:0:0:Ab:FFFF", "::", "::1", "FE80::",
        "1:2:3:4:5:6:7:8:9", "12345::1", "1:::2", "1::2::3", "g.1.1.1", "1234",
        ":1:2:3:4:5:6:7", "1:2:3:4:5:6:7:", "1:2:3:4:5:6::7", "1:2:3:4::5:6:7:8"
    };
    string directed_strict[] = '{"::1", "0:0:0:0:0:0:0:0", "1:2:3:4:5:6:7"};

    ip_address_text_validator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_char     (text_char),
        .is_final_char (is_final_char),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .address_class (address_class)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result monitor and watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
            sb.check_result(ipatv_pkg::addr_class_t'(address_class));
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: short random stalls, plus one long hold so the block backs up
    initial
    begin
        int burst;
        int hold;
        bit held_once;
        burst = 0;
        hold = 0;
        held_once = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_once && sb.chars_noted >= HOLD_AFTER_CHARS)
            begin
                held_once = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 3) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        text_char     <= c;
        is_final_char <= fin;
        do @(posedge clk); while (in_stall);
        sb.note_request(c, fin);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++)
            send_char(t[i], i == t.len() - 1);
    endtask

    task automatic send_bytes(ref logic [7:0] s[$]);
        for (int i = 0; i < s.size(); i++)
            send_char(s[i], i == s.size() - 1);
    endtask

    // Let every queued character drain before the register changes
    task automatic drain_pending();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_compression(input logic on);
        drain_pending();
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.compression_on = on;
        settings_used++;
    endtask

    function automatic void append_decimal(ref logic [7:0] s[$], input int unsigned v);
        string t;
        t = $sformatf("%0d", v);
        for (int i = 0; i < t.len(); i++) s = {s, t[i]};
    endfunction

    function automatic logic [7:0] hex_char(input int unsigned n);
        logic [7:0] c;
        if (n < 10) return ASCII_ZERO + n[7:0];
        c = ASCII_LOWER_A + n[7:0] - 8'd10;
        if ($urandom_range(0, 1)) c = c - CASE_OFFSET;
        return c;
    endfunction

    function automatic void build_v4(ref logic [7:0] s[$]);
        int unsigned n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 4;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0) s = {s, ASCII_DOT};
            case ($urandom_range(0, 11))
                0: begin
                    s = {s, ASCII_ZERO};
                    append_decimal(s, $urandom_range(0, 99));
                end
                1: append_decimal(s, $urandom_range(256, 9999));
                2: ;
                3: append_decimal(s, 255);
                4: append_decimal(s, 0);
                default: append_decimal(s, $urandom_range(0, 255));
            endcase
        end
    endfunction

    function automatic void append_hex_group(ref logic [7:0] s[$]);
        int unsigned len;
        len = ($urandom_range(0, 11) == 0) ? 5 : $urandom_range(1, 4);
        repeat (len)
        begin
            if ($urandom_range(0, 3) == 0)
                s = {s, hex_char($urandom_range(0, 1) ? 15 : 0)};
            else
                s = {s, hex_char($urandom_range(0, 15))};
        end
    endfunction

    function automatic void build_v6(ref logic [7:0] s[$]);
        bit          compress;
        int unsigned n;
        int unsigned gap_at;
        compress = 1'($urandom_range(0, 1));
        if (compress)
        begin
            n = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(0, 7);
            gap_at = $urandom_range(0, n);
        end
        else
        begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 9) : 8;
            gap_at = n + 1;
        end
        for (int i = 0; i < n; i++)
        begin
            if (compress && i == gap_at)
            begin
                s = {s, ASCII_COLON};
                s = {s, ASCII_COLON};
            end
            else if (i > 0)
                s = {s, ASCII_COLON};
            append_hex_group(s);
        end
        if (compress && gap_at == n)
        begin
            s = {s, ASCII_COLON};
            s = {s, ASCII_COLON};
        end
    endfunction

    function automatic void build_noise(ref logic [7:0] s[$]);
        string alphabet;
        alphabet = "0123456789abcdefABCDEF.:xgZ ";
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(0, 1))
                s = {s, 8'($urandom_range(0, 255))};
            else
                s = {s, alphabet[$urandom_range(0, alphabet.len() - 1)]};
        end
    endfunction

    function automatic void corrupt_text(ref logic [7:0] s[$]);
        int unsigned pos;
        pos = $urandom_range(0, s.size() - 1);
        case ($urandom_range(0, 3))
            0: s[pos] = 8'($urandom_range(0, 255));
            1: s[pos] = $urandom_range(0, 1) ? ASCII_DOT : ASCII_COLON;
            2: if (s.size() > 1) s.delete(pos);
            default: s.insert(pos, ASCII_COLON);
        endcase
    endfunction

    initial
    begin
        logic [7:0]  text[$];
        int unsigned pick;
        int unsigned phase_end;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= 1'b0;
        in_valid      <= 1'b0;
        text_char     <= '0;
        is_final_char <= 1'b0;
        settings_used = 1;
        idle_on       = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_compressed[i]) send_text(directed_compressed[i]);
        write_compression(1'b0);
        foreach (directed_strict[i]) send_text(directed_strict[i]);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_compression((p % 2 == 0) ? 1'b1 : 1'b0);
            // final phase runs at full rate on both sides
            if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
            phase_end = sb.chars_noted + RANDOM_ITEMS / RANDOM_PHASES;
            while (sb.chars_noted < phase_end)
            begin
                text.delete();
                pick = $urandom_range(0, 19);
                if (pick < 8) build_v4(text);
                else if (pick < 16) build_v6(text);
                else build_noise(text);
                if (text.size() == 0) text = {text, 8'($urandom_range(0, 255))};
                if (pick < 16 && $urandom_range(0, 4) == 0) corrupt_text(text);
                send_bytes(text);
            end
        end

        drain_pending();
        $display("Covered %0d characters in %0d address strings over %0d register settings.",
                 sb.chars_noted, sb.strings_noted, settings_used);
        $display("Checked %0d classifications, %0d mismatches.",
                 sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
